// ----- hdl/idcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_pkg
// Shared types and constants for the incremental difference cosine fit block.
// ----------------------------------------------------------------------------
package idcf_pkg;

    // Item kinds.
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_THREE   = 3'd1;
    localparam logic [2:0] KIND_ONE     = 3'd2;
    localparam logic [2:0] KIND_PAIR    = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    // Reset value of the point count register.
    localparam logic [8:0] POINTS_RESET = 9'd256;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         target_index;
        logic signed [31:0] target_value;
        logic signed [31:0] point_a;
        logic signed [31:0] point_b;
        logic signed [31:0] point_c;
        logic               commit;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic [1:0]         status;
    } out_item_t;

    // What the decoded item needs from the sequencer.
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_WRITE,
        CLS_SCORE,
        CLS_RESTART
    } item_cls_t;

    // Operation carried by the shared multiplier.
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_DT,
        MOP_DD,
        MOP_TT,
        MOP_W0,
        MOP_W1,
        MOP_W2,
        MOP_W3
    } mul_op_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_CFG,
        CS_DECODE,
        CS_FETCH,
        CS_MUL_DT,
        CS_MUL_DD,
        CS_MUL_TT,
        CS_DRAIN,
        CS_WIDE,
        CS_WIDE_DRAIN,
        CS_ROOT_GO,
        CS_ROOT_WAIT,
        CS_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_SQRT,
        RD_CHECK,
        RD_DIV,
        RD_DONE
    } rd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    prep_restart;
        logic    mem_we;
        logic    fetch;
        logic    term_sel;
        mul_op_t mul_op;
        logic    root_start;
        logic    finish;
        logic    emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        item_cls_t cls;
        logic      two_terms;
        logic      root_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/idcf_rootdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_rootdiv
// Bit-serial square root of a 128-bit product followed by a bit-serial
// fraction divide that turns the dot product into a signed Q1.30 cosine.
// ----------------------------------------------------------------------------
module idcf_rootdiv (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [127:0]        radicand,
    input  wire logic [63:0]         dot,
    output logic                     done,
    output logic signed [31:0]       score,
    output logic                     zero_den
);

    idcf_pkg::rd_state_t state_reg, state_next;

    logic [5:0]   cnt_reg;
    logic [127:0] rad_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [63:0]  mag_reg;
    logic         neg_reg;
    logic [30:0]  q_reg;
    logic         zero_reg;
    logic [63:0]  drem_reg;

    logic [67:0]  sq_tmp;
    logic [67:0]  sq_trial;
    logic [67:0]  sq_diff;
    logic         sq_ge;
    logic [64:0]  dv_tmp;
    logic [64:0]  dv_diff;
    logic         dv_ge;

    // One root bit per cycle: bring down two radicand bits, try the subtract.
    assign sq_tmp   = {rem_reg, rad_reg[127:126]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_tmp >= sq_trial);
    assign sq_diff  = sq_tmp - sq_trial;

    // One quotient bit per cycle of a restoring divide.
    assign dv_tmp  = {drem_reg, 1'b0};
    assign dv_ge   = (dv_tmp >= {1'b0, root_reg});
    assign dv_diff = dv_tmp - {1'b0, root_reg};

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idcf_pkg::RD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            idcf_pkg::RD_IDLE:
            begin
                if (start)
                begin
                    state_next = idcf_pkg::RD_SQRT;
                end
            end
            idcf_pkg::RD_SQRT:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = idcf_pkg::RD_CHECK;
                end
            end
            idcf_pkg::RD_CHECK:
            begin
                if (root_reg == 64'd0 || mag_reg >= root_reg)
                begin
                    state_next = idcf_pkg::RD_DONE;
                end
                else
                begin
                    state_next = idcf_pkg::RD_DIV;
                end
            end
            idcf_pkg::RD_DIV:
            begin
                if (cnt_reg == 6'd29)
                begin
                    state_next = idcf_pkg::RD_DONE;
                end
            end
            idcf_pkg::RD_DONE:
            begin
                done       = 1'b1;
                state_next = idcf_pkg::RD_IDLE;
            end
            default:
            begin
                state_next = idcf_pkg::RD_IDLE;
            end
        endcase
    end

    // Working registers of the root and divide iterations.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            idcf_pkg::RD_IDLE:
            begin
                if (start)
                begin
                    rad_reg  <= radicand;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    mag_reg  <= dot[63] ? (64'd0 - dot) : dot;
                    neg_reg  <= dot[63];
                end
            end
            idcf_pkg::RD_SQRT:
            begin
                rad_reg <= {rad_reg[125:0], 2'b00};
                cnt_reg <= cnt_reg + 6'd1;
                if (sq_ge)
                begin
                    rem_reg  <= sq_diff[65:0];
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_tmp[65:0];
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            idcf_pkg::RD_CHECK:
            begin
                zero_reg <= (root_reg == 64'd0);
                cnt_reg  <= '0;
                drem_reg <= mag_reg;
                if (root_reg != 64'd0 && mag_reg >= root_reg)
                begin
                    q_reg <= 31'h4000_0000;
                end
                else
                begin
                    q_reg <= '0;
                end
            end
            idcf_pkg::RD_DIV:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (dv_ge)
                begin
                    drem_reg <= dv_diff[63:0];
                    q_reg    <= {q_reg[29:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dv_tmp[63:0];
                    q_reg    <= {q_reg[29:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Apply the sign of the dot product.
    assign score    = neg_reg ? (32'sd0 - $signed({1'b0, q_reg})) : $signed({1'b0, q_reg});
    assign zero_den = zero_reg;

endmodule

`default_nettype wire

// ----- hdl/idcf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_datapath
// Target table, fit state, shared 32x32 multiplier, running accumulators,
// and the root/divide unit, all stepped by controller commands.
// ----------------------------------------------------------------------------
module idcf_datapath #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire idcf_pkg::ctrl_cmd_t  cmd,
    output idcf_pkg::dp_status_t      status,
    input  wire idcf_pkg::in_item_t   in_data,
    input  wire logic                 cfg_we,
    input  wire logic [8:0]           cfg_data,
    output idcf_pkg::out_item_t       out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = AW + 1;
    localparam int RESET_N = (256 > MAX_POINTS) ? MAX_POINTS : 256;

    // Architectural state.
    logic [8:0]           points_reg;
    logic signed [NW-1:0] fit_pos_reg;
    logic signed [31:0]   latest_reg;
    logic [63:0]          dot_sum_reg;
    logic [63:0]          fit_norm_reg;
    logic [63:0]          tgt_norm_reg;

    // Per-item working registers.
    idcf_pkg::in_item_t   item_reg;
    idcf_pkg::item_cls_t  cls_reg;
    logic [1:0]           stat_reg;
    logic                 two_reg;
    logic                 restart_reg;
    logic signed [32:0]   d0_reg;
    logic signed [32:0]   d1_reg;
    logic [AW-1:0]        addr0_reg;
    logic [AW-1:0]        addr1_reg;
    logic [63:0]          acc_dot_reg;
    logic [63:0]          acc_n1_reg;
    logic [63:0]          acc_n2_reg;
    logic [127:0]         wide_reg;
    logic signed [31:0]   mem_q;
    logic [63:0]          prod_reg;
    logic                 neg_reg;
    idcf_pkg::mul_op_t    tag_reg;
    idcf_pkg::out_item_t  out_reg;

    logic [31:0] store_mem [MAX_POINTS];

    logic [NW-1:0]        n_used;
    logic [AW-1:0]        n_m3;
    logic [AW-1:0]        n_m2;
    logic signed [NW-1:0] fp_reset;
    logic                 fp_neg;
    logic                 fp_lt1;

    idcf_pkg::item_cls_t  p_cls;
    logic [1:0]           p_stat;
    logic                 p_two;
    logic                 p_restart;
    logic signed [32:0]   p_d0;
    logic signed [32:0]   p_d1;
    logic [AW-1:0]        p_a0;
    logic [AW-1:0]        p_a1;
    logic [63:0]          p_dot;
    logic [63:0]          p_n1;
    logic [63:0]          p_n2;

    logic signed [32:0]   d_sel;
    logic [31:0]          d_mag;
    logic [31:0]          t_mag;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic                 mul_neg;
    logic signed [64:0]   dt_signed;
    logic signed [64:0]   dt_shift;

    logic                 rd_done;
    logic signed [31:0]   rd_score;
    logic                 rd_zero;

    // Clamp the point count to the usable range.
    always_comb
    begin
        if (points_reg < 9'd4)
        begin
            n_used = NW'(4);
        end
        else if (32'(points_reg) > 32'(MAX_POINTS))
        begin
            n_used = NW'(MAX_POINTS);
        end
        else
        begin
            n_used = NW'(points_reg);
        end
    end

    assign n_m3     = AW'(n_used - NW'(3));
    assign n_m2     = AW'(n_used - NW'(2));
    assign fp_reset = $signed(n_used - NW'(4));
    assign fp_neg   = fit_pos_reg[NW-1];
    assign fp_lt1   = fp_neg || (fit_pos_reg == '0);

    // Decode an accepted item, or a restart after a configuration write.
    always_comb
    begin
        p_cls     = idcf_pkg::CLS_NONE;
        p_stat    = idcf_pkg::STAT_OK;
        p_two     = 1'b1;
        p_restart = 1'b0;
        p_d0      = '0;
        p_d1      = '0;
        p_a0      = n_m3;
        p_a1      = n_m2;
        p_dot     = '0;
        p_n1      = '0;
        p_n2      = '0;
        if (cmd.prep_restart)
        begin
            p_cls     = idcf_pkg::CLS_RESTART;
            p_restart = 1'b1;
        end
        else
        begin
            case (in_data.kind)
                idcf_pkg::KIND_LOAD:
                begin
                    if (32'(in_data.target_index) < 32'(MAX_POINTS))
                    begin
                        p_cls = idcf_pkg::CLS_WRITE;
                    end
                    else
                    begin
                        p_stat = idcf_pkg::STAT_RANGE;
                    end
                end
                idcf_pkg::KIND_THREE:
                begin
                    p_cls = idcf_pkg::CLS_SCORE;
                    p_d0  = {in_data.point_b[31], in_data.point_b}
                          - {in_data.point_a[31], in_data.point_a};
                    p_d1  = {in_data.point_c[31], in_data.point_c}
                          - {in_data.point_b[31], in_data.point_b};
                end
                idcf_pkg::KIND_ONE:
                begin
                    if (fp_neg)
                    begin
                        p_stat = idcf_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        p_cls = idcf_pkg::CLS_SCORE;
                        p_two = 1'b0;
                        p_d0  = {latest_reg[31], latest_reg}
                              - {in_data.point_a[31], in_data.point_a};
                        p_a0  = AW'(fit_pos_reg);
                        p_dot = dot_sum_reg;
                        p_n1  = fit_norm_reg;
                        p_n2  = tgt_norm_reg;
                    end
                end
                idcf_pkg::KIND_PAIR:
                begin
                    if (fp_lt1)
                    begin
                        p_stat = idcf_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        p_cls = idcf_pkg::CLS_SCORE;
                        p_d0  = {in_data.point_b[31], in_data.point_b}
                              - {in_data.point_a[31], in_data.point_a};
                        p_d1  = {latest_reg[31], latest_reg}
                              - {in_data.point_b[31], in_data.point_b};
                        p_a0  = AW'(fit_pos_reg - NW'(1));
                        p_a1  = AW'(fit_pos_reg);
                    end
                end
                idcf_pkg::KIND_RESTART:
                begin
                    p_cls     = idcf_pkg::CLS_RESTART;
                    p_restart = 1'b1;
                end
                default:
                begin
                    p_cls = idcf_pkg::CLS_NONE;
                end
            endcase
        end
    end

    // Target table with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            store_mem[AW'(item_reg.target_index)] <= item_reg.target_value;
        end
        if (cmd.fetch)
        begin
            mem_q <= store_mem[cmd.term_sel ? addr1_reg : addr0_reg];
        end
    end

    // Multiplier operand selection.
    assign d_sel = cmd.term_sel ? d1_reg : d0_reg;
    assign d_mag = d_sel[32] ? 32'(33'sd0 - d_sel) : d_sel[31:0];
    assign t_mag = mem_q[31] ? (32'd0 - mem_q) : mem_q;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.mul_op)
            idcf_pkg::MOP_DT:
            begin
                mul_a   = d_mag;
                mul_b   = t_mag;
                mul_neg = d_sel[32] ^ mem_q[31];
            end
            idcf_pkg::MOP_DD:
            begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            idcf_pkg::MOP_TT:
            begin
                mul_a = t_mag;
                mul_b = t_mag;
            end
            idcf_pkg::MOP_W0:
            begin
                mul_a = acc_n1_reg[31:0];
                mul_b = acc_n2_reg[31:0];
            end
            idcf_pkg::MOP_W1:
            begin
                mul_a = acc_n1_reg[31:0];
                mul_b = acc_n2_reg[63:32];
            end
            idcf_pkg::MOP_W2:
            begin
                mul_a = acc_n1_reg[63:32];
                mul_b = acc_n2_reg[31:0];
            end
            idcf_pkg::MOP_W3:
            begin
                mul_a = acc_n1_reg[63:32];
                mul_b = acc_n2_reg[63:32];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Shared multiplier, registered output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= idcf_pkg::MOP_NONE;
        end
        else
        begin
            tag_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        neg_reg  <= mul_neg;
    end

    // Signed product rounded toward minus infinity to Q.16.
    assign dt_signed = neg_reg ? (65'sd0 - $signed({1'b0, prod_reg}))
                               : $signed({1'b0, prod_reg});
    assign dt_shift  = dt_signed >>> 16;

    // Item decode and accumulation of the product terms.
    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.prep_restart)
        begin
            two_reg     <= p_two;
            d0_reg      <= p_d0;
            d1_reg      <= p_d1;
            addr0_reg   <= p_a0;
            addr1_reg   <= p_a1;
            acc_dot_reg <= p_dot;
            acc_n1_reg  <= p_n1;
            acc_n2_reg  <= p_n2;
            wide_reg    <= '0;
            stat_reg    <= p_stat;
        end
        else
        begin
            case (tag_reg)
                idcf_pkg::MOP_DT: acc_dot_reg <= acc_dot_reg + dt_shift[63:0];
                idcf_pkg::MOP_DD: acc_n1_reg  <= acc_n1_reg + {16'd0, prod_reg[63:16]};
                idcf_pkg::MOP_TT: acc_n2_reg  <= acc_n2_reg + {16'd0, prod_reg[63:16]};
                idcf_pkg::MOP_W0: wide_reg    <= wide_reg + {64'd0, prod_reg};
                idcf_pkg::MOP_W1: wide_reg    <= wide_reg + {32'd0, prod_reg, 32'd0};
                idcf_pkg::MOP_W2: wide_reg    <= wide_reg + {32'd0, prod_reg, 32'd0};
                idcf_pkg::MOP_W3: wide_reg    <= wide_reg + {prod_reg, 64'd0};
                default:
                begin
                end
            endcase
        end
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
    end

    // Item class and restart flag are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg     <= idcf_pkg::CLS_NONE;
            restart_reg <= 1'b0;
        end
        else if (cmd.accept || cmd.prep_restart)
        begin
            cls_reg     <= p_cls;
            restart_reg <= p_restart;
        end
    end

    // Configuration register, written on cfg_we, and fit state, updated when the item finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg   <= idcf_pkg::POINTS_RESET;
            fit_pos_reg  <= NW'(RESET_N - 4);
            latest_reg   <= '0;
            dot_sum_reg  <= '0;
            fit_norm_reg <= '0;
            tgt_norm_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                points_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                if (restart_reg)
                begin
                    fit_pos_reg  <= fp_reset;
                    dot_sum_reg  <= '0;
                    fit_norm_reg <= '0;
                    tgt_norm_reg <= acc_n2_reg;
                end
                else if (cls_reg == idcf_pkg::CLS_SCORE && item_reg.commit)
                begin
                    if (item_reg.kind == idcf_pkg::KIND_THREE)
                    begin
                        latest_reg   <= item_reg.point_a;
                        dot_sum_reg  <= acc_dot_reg;
                        fit_norm_reg <= acc_n1_reg;
                        tgt_norm_reg <= acc_n2_reg;
                        fit_pos_reg  <= fp_reset;
                    end
                    else if (item_reg.kind == idcf_pkg::KIND_ONE)
                    begin
                        latest_reg   <= item_reg.point_a;
                        dot_sum_reg  <= acc_dot_reg;
                        fit_norm_reg <= acc_n1_reg;
                        tgt_norm_reg <= acc_n2_reg;
                        fit_pos_reg  <= fit_pos_reg - NW'(1);
                    end
                end
            end
        end
    end

    // Square root of the norm product and the final divide.
    idcf_rootdiv u_rootdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (wide_reg),
        .dot      (acc_dot_reg),
        .done     (rd_done),
        .score    (rd_score),
        .zero_den (rd_zero)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cls_reg == idcf_pkg::CLS_SCORE)
            begin
                out_reg.score  <= rd_score;
                out_reg.status <= rd_zero ? idcf_pkg::STAT_ZERO_DEN : idcf_pkg::STAT_OK;
            end
            else
            begin
                out_reg.score  <= '0;
                out_reg.status <= stat_reg;
            end
        end
    end

    assign out_data         = out_reg;
    assign status.cls       = cls_reg;
    assign status.two_terms = two_reg;
    assign status.root_done = rd_done;

endmodule

`default_nettype wire

// ----- hdl/idcf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idcf_ctrl
// Sequencer: accepts items and configuration restarts, steps the datapath
// through table reads, products, root and divide, and owns the result valid.
// ----------------------------------------------------------------------------
module idcf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire logic                 cfg_we,
    input  wire idcf_pkg::dp_status_t status,
    output idcf_pkg::ctrl_cmd_t       cmd
);

    idcf_pkg::ctrl_state_t state_reg, state_next;
    logic       term_reg, term_next;
    logic [1:0] wide_reg, wide_next;
    logic       cfg_reg, cfg_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idcf_pkg::CS_IDLE;
            term_reg      <= 1'b0;
            wide_reg      <= '0;
            cfg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            wide_reg      <= wide_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        term_next        = term_reg;
        wide_next        = wide_reg;
        cfg_next         = cfg_reg;
        cmd.accept       = 1'b0;
        cmd.prep_restart = 1'b0;
        cmd.mem_we       = 1'b0;
        cmd.fetch        = 1'b0;
        cmd.term_sel     = term_reg;
        cmd.mul_op       = idcf_pkg::MOP_NONE;
        cmd.root_start   = 1'b0;
        cmd.finish       = 1'b0;
        cmd.emit         = 1'b0;
        case (state_reg)
            idcf_pkg::CS_IDLE:
            begin
                if (cfg_we)
                begin
                    cfg_next   = 1'b1;
                    state_next = idcf_pkg::CS_CFG;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cfg_next   = 1'b0;
                    state_next = idcf_pkg::CS_DECODE;
                end
            end
            idcf_pkg::CS_CFG:
            begin
                cmd.prep_restart = 1'b1;
                state_next       = idcf_pkg::CS_DECODE;
            end
            idcf_pkg::CS_DECODE:
            begin
                term_next = 1'b0;
                wide_next = '0;
                case (status.cls)
                    idcf_pkg::CLS_WRITE:
                    begin
                        cmd.mem_we = 1'b1;
                        state_next = idcf_pkg::CS_FINISH;
                    end
                    idcf_pkg::CLS_SCORE,
                    idcf_pkg::CLS_RESTART:
                    begin
                        state_next = idcf_pkg::CS_FETCH;
                    end
                    default:
                    begin
                        state_next = idcf_pkg::CS_FINISH;
                    end
                endcase
            end
            idcf_pkg::CS_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = idcf_pkg::CS_MUL_DT;
            end
            idcf_pkg::CS_MUL_DT:
            begin
                cmd.mul_op = idcf_pkg::MOP_DT;
                state_next = idcf_pkg::CS_MUL_DD;
            end
            idcf_pkg::CS_MUL_DD:
            begin
                cmd.mul_op = idcf_pkg::MOP_DD;
                state_next = idcf_pkg::CS_MUL_TT;
            end
            idcf_pkg::CS_MUL_TT:
            begin
                cmd.mul_op = idcf_pkg::MOP_TT;
                if (!term_reg && status.two_terms)
                begin
                    term_next  = 1'b1;
                    state_next = idcf_pkg::CS_FETCH;
                end
                else
                begin
                    state_next = idcf_pkg::CS_DRAIN;
                end
            end
            idcf_pkg::CS_DRAIN:
            begin
                if (status.cls == idcf_pkg::CLS_RESTART)
                begin
                    state_next = idcf_pkg::CS_FINISH;
                end
                else
                begin
                    state_next = idcf_pkg::CS_WIDE;
                end
            end
            idcf_pkg::CS_WIDE:
            begin
                case (wide_reg)
                    2'd0:    cmd.mul_op = idcf_pkg::MOP_W0;
                    2'd1:    cmd.mul_op = idcf_pkg::MOP_W1;
                    2'd2:    cmd.mul_op = idcf_pkg::MOP_W2;
                    default: cmd.mul_op = idcf_pkg::MOP_W3;
                endcase
                wide_next = wide_reg + 2'd1;
                if (wide_reg == 2'd3)
                begin
                    state_next = idcf_pkg::CS_WIDE_DRAIN;
                end
            end
            idcf_pkg::CS_WIDE_DRAIN:
            begin
                state_next = idcf_pkg::CS_ROOT_GO;
            end
            idcf_pkg::CS_ROOT_GO:
            begin
                cmd.root_start = 1'b1;
                state_next     = idcf_pkg::CS_ROOT_WAIT;
            end
            idcf_pkg::CS_ROOT_WAIT:
            begin
                if (status.root_done)
                begin
                    state_next = idcf_pkg::CS_FINISH;
                end
            end
            idcf_pkg::CS_FINISH:
            begin
                // A restart after a configuration write gives no result.
                if (cfg_reg || slot_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.emit   = !cfg_reg;
                    state_next = idcf_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = idcf_pkg::CS_IDLE;
            end
        endcase
    end

    // Result valid: set on a new result, cleared by its transfer.
    assign out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != idcf_pkg::CS_IDLE) || cfg_we;

endmodule

`default_nettype wire

// ----- hdl/incremental_difference_cosine_fit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_difference_cosine_fit
// Cosine similarity between successive point differences and a loaded table
// of target differences, grown leftward with running sums.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Load items, flagged items, unused kinds
// and items without table work are taken, decoded and finished; a reset-sums
// item also reads two table entries and forms their products. A scored item
// is taken and decoded; each of its one or two differences gets a table read
// and its products on the shared 32x32 multiplier; then come a drain, the
// 128-bit norm product and the root start, the one-bit-per-cycle square root,
// a root check, the one-bit-per-cycle divide, the hand-back of the quotient
// and the finish. A zero denominator or a saturated score skips the divide.
// The user must give a configuration write while the block is idle; the block
// does not enforce this. It is followed by a reset-sums pass that gives no
// result. A finished result waits in an output register while the next item
// is taken; a later item does not finish until that register is free.
// ----------------------------------------------------------------------------
module incremental_difference_cosine_fit #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire idcf_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output idcf_pkg::out_item_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic [8:0]           cfg_data
);

    idcf_pkg::ctrl_cmd_t  cmd;
    idcf_pkg::dp_status_t status;

    // Sequencer.
    idcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage.
    idcf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
